// ===== rtl/bdet_pkg.sv =====
// package for the button press event detector
// shared types, event codes, register map and reset values; no dependencies
package bdet_pkg;

  // event codes carried in each result word
  typedef enum logic [1:0] {
    EvDown  = 2'd0,
    EvUp    = 2'd1,
    EvLong  = 2'd2,
    EvCombo = 2'd3
  } ev_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    RegDebounce  = 2'd0,
    RegLongPress = 2'd1,
    RegCombo     = 2'd2,
    RegNone      = 2'd3
  } reg_e;

  localparam int unsigned ApbAddrW   = 4;
  localparam int unsigned ApbDataW   = 32;
  localparam int unsigned TimeW      = 32;
  localparam int unsigned DurW       = 16;
  localparam int unsigned CountW     = 8;
  localparam int unsigned MaxEvents  = 3;

  localparam logic [DurW-1:0]   DebounceReset  = 16'd20;
  localparam logic [DurW-1:0]   LongPressReset = 16'd1000;
  localparam logic [CountW-1:0] ComboReset     = 8'd2;
  localparam logic [CountW-1:0] CountMax       = 8'd255;

  localparam int unsigned QueueDepthDefault = 4;

  typedef struct packed {
    logic [DurW-1:0]   debounce_ms;
    logic [DurW-1:0]   long_press_ms;
    logic [CountW-1:0] combo_threshold;
  } cfg_t;

  // events caused by one sample, ev[0] first, n of them valid (1 to 3)
  typedef struct packed {
    logic [1:0]                n;
    logic [MaxEvents-1:0][1:0] ev;
  } bundle_t;

  typedef struct packed {
    logic    valid;
    bundle_t data;
  } push_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

// ===== rtl/bdet_if.sv =====
// handshake channels of the button press event detector
// depends on bdet_pkg for field widths
interface bdet_sample_if
  import bdet_pkg::*;
();
  logic             valid;
  logic             ready;
  logic             level;
  logic [TimeW-1:0] now_ms;

  modport source (output valid, output level, output now_ms, input ready);
  modport sink (input valid, input level, input now_ms, output ready);
endinterface

interface bdet_event_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic       last;

  modport source (output valid, output event_res, output last, input ready);
  modport sink (input valid, input event_res, input last, output ready);
endinterface

// ===== rtl/button_press_event_detector.sv =====
// button press event detector: one sample word in, up to three event words out
// sample to event: a bundle enters the queue on the accepting edge, then its words pass the output register
// throughput: one sample per cycle while the bundle queue has room; words leave
// one per cycle from the output register, so the event port sets the drain rate
// reset: asynchronous active low, clears debounce state, press count and queue,
// loads the register defaults (debounce 20, long press 1000, combo 2)
module button_press_event_detector
  import bdet_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDefault
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  bdet_sample_if.sink         sample_i,
  bdet_event_if.source        event_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready
);

  cfg_t    cfg;
  push_t   push;
  bundle_t head;
  q_stat_t q_stat;
  logic    pop;

  // register block
  bdet_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // front: debounce and event classification, one sample a cycle while the queue has room
  bdet_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_i),
    .cfg_i    (cfg),
    .q_stat_i (q_stat),
    .push_o   (push)
  );

  // samples that cause no event never enter the queue
  bdet_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .head_o (head),
    .stat_o (q_stat)
  );

  // back: serialise bundles, mark the last word of each
  bdet_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .q_stat_i (q_stat),
    .pop_o    (pop),
    .event_o  (event_o)
  );

  // front never pushes into a full queue
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !q_stat.full)
    else $error("bundle pushed into full queue");

  // back only pops a queue that holds something
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !q_stat.empty)
    else $error("pop from empty queue");

  // a new word appears only if the queue held a bundle
  a_word_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(event_o.valid) |-> $past(!q_stat.empty))
    else $error("event word without queued bundle");

endmodule

// ===== rtl/bdet_cfg.sv =====
// apb register block: debounce time, long press time, combo threshold
// depends on bdet_pkg
module bdet_cfg
  import bdet_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [ApbDataW-1:0] pwdata,
  output logic [ApbDataW-1:0] prdata,
  output logic                pready,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;
  reg_e sel;
  logic wr_en;

  assign sel    = reg_e'(paddr[3:2]);
  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (sel)
        RegDebounce:  cfg_d.debounce_ms     = pwdata[DurW-1:0];
        RegLongPress: cfg_d.long_press_ms   = pwdata[DurW-1:0];
        RegCombo:     cfg_d.combo_threshold = pwdata[CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (sel)
      RegDebounce:  prdata = ApbDataW'(cfg_q.debounce_ms);
      RegLongPress: prdata = ApbDataW'(cfg_q.long_press_ms);
      RegCombo:     prdata = ApbDataW'(cfg_q.combo_threshold);
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce_ms     <= DebounceReset;
      cfg_q.long_press_ms   <= LongPressReset;
      cfg_q.combo_threshold <= ComboReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/bdet_front.sv =====
// front part: takes samples, tracks debounce state, builds the event bundle
// depends on bdet_pkg and bdet_if
module bdet_front
  import bdet_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  bdet_sample_if.sink   sample_i,
  input  cfg_t          cfg_i,
  input  q_stat_t       q_stat_i,
  output push_t         push_o
);

  logic              held_q, held_d;
  logic              pending_q, pending_d;
  logic              down_q, down_d;
  logic [TimeW-1:0]  change_time_q, change_time_d;
  logic [CountW-1:0] count_q, count_d;

  logic              accept;
  logic              same;
  logic              take;
  logic [TimeW-1:0]  elapsed;
  logic [TimeW-1:0]  elapsed_long;
  bundle_t           bundle;

  assign sample_i.ready = !q_stat_i.full;
  assign accept         = sample_i.valid && sample_i.ready;
  assign same           = (sample_i.level == held_q);
  assign elapsed        = sample_i.now_ms - change_time_q;
  assign take           = same && pending_q && (elapsed >= TimeW'(cfg_i.debounce_ms));
  // a level change restarts the clock, so nothing has elapsed
  assign elapsed_long   = same ? elapsed : '0;

  always_comb begin
    held_d        = held_q;
    pending_d     = pending_q;
    down_d        = down_q;
    change_time_d = change_time_q;
    count_d       = count_q;
    bundle        = '0;
    if (!same) begin
      pending_d     = 1'b1;
      held_d        = sample_i.level;
      change_time_d = sample_i.now_ms;
    end else if (take) begin
      pending_d = 1'b0;
      if (!held_q) begin
        down_d       = 1'b1;
        bundle.ev[0] = EvDown;
        count_d      = (count_q == CountMax) ? count_q : count_q + 1'b1;
        if (count_d >= cfg_i.combo_threshold) begin
          bundle.ev[1] = EvCombo;
          bundle.n     = 2'd2;
        end else begin
          bundle.n = 2'd1;
        end
      end else begin
        down_d       = 1'b0;
        bundle.ev[0] = EvUp;
        bundle.n     = 2'd1;
      end
    end
    if (down_d && (elapsed_long >= TimeW'(cfg_i.long_press_ms))) begin
      down_d              = 1'b0;
      bundle.ev[bundle.n] = EvLong;
      bundle.n            = bundle.n + 2'd1;
    end
  end

  assign push_o.valid = accept && (bundle.n != 2'd0);
  assign push_o.data  = bundle;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q        <= 1'b0;
      pending_q     <= 1'b0;
      down_q        <= 1'b0;
      change_time_q <= '0;
      count_q       <= '0;
    end else if (accept) begin
      held_q        <= held_d;
      pending_q     <= pending_d;
      down_q        <= down_d;
      change_time_q <= change_time_d;
      count_q       <= count_d;
    end
  end

endmodule

// ===== rtl/bdet_queue.sv =====
// short bundle queue between the front and back parts
// depends on bdet_pkg
module bdet_queue
  import bdet_pkg::*;
#(
  parameter int unsigned Depth = QueueDepthDefault
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  push_t   push_i,
  input  logic    pop_i,
  output bundle_t head_o,
  output q_stat_t stat_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  bundle_t           mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   cnt_q;
  logic              do_push, do_pop;

  assign stat_o.full  = (cnt_q == CntW'(Depth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push      = push_i.valid && !stat_o.full;
  assign do_pop       = pop_i && !stat_o.empty;
  assign head_o       = mem_q[rd_ptr_q];

  function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
    return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= bump(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= bump(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/bdet_back.sv =====
// back part: splits each bundle into words behind an output register
// depends on bdet_pkg and bdet_if
module bdet_back
  import bdet_pkg::*;
(
  input  logic          clk_i,
  input  logic          rst_ni,
  input  bundle_t       head_i,
  input  q_stat_t       q_stat_i,
  output logic          pop_o,
  bdet_event_if.source  event_o
);

  logic       valid_q;
  logic [1:0] ev_q;
  logic       last_q;
  logic [1:0] idx_q;
  logic       load;
  logic       step;
  logic       word_last;

  assign load      = !valid_q || event_o.ready;
  assign step      = load && !q_stat_i.empty;
  assign word_last = (idx_q == head_i.n - 2'd1);
  assign pop_o     = step && word_last;

  assign event_o.valid     = valid_q;
  assign event_o.event_res = ev_q;
  assign event_o.last      = last_q;

  always_ff @(posedge clk_i) begin
    if (step) begin
      ev_q   <= head_i.ev[idx_q];
      last_q <= word_last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      if (load) begin
        valid_q <= !q_stat_i.empty;
      end
      if (step) begin
        idx_q <= word_last ? 2'd0 : idx_q + 2'd1;
      end
    end
  end

endmodule

// ===== dv/tb_button_press_event_detector.sv =====
// testbench for button_press_event_detector: directed and random sample words,
// apb register writes with read-back, event words checked against a predictor
// depends on bdet_pkg, bdet_if.sv and the rtl top level
module tb_button_press_event_detector;
  import bdet_pkg::*;

  // one expected event word
  typedef struct packed {
    ev_e  code;
    logic last;
  } ev_word_t;

  // tracks debounce state and press count, holds the event words still due
  class press_event_tracker;
    logic [DurW-1:0]   debounce_ms;
    logic [DurW-1:0]   long_press_ms;
    logic [CountW-1:0] combo_threshold;
    logic              held_level;
    logic              change_pending;
    logic              is_down;
    logic [TimeW-1:0]  change_time;
    logic [CountW-1:0] press_count;
    ev_word_t          due_events[$];
    int unsigned       mismatch_cnt;

    function new();
      debounce_ms     = DebounceReset;
      long_press_ms   = LongPressReset;
      combo_threshold = ComboReset;
      held_level      = 1'b0;
      change_pending  = 1'b0;
      is_down         = 1'b0;
      change_time     = '0;
      press_count     = '0;
      mismatch_cnt    = 0;
    endfunction

    function void report(string msg);
      mismatch_cnt++;
      if (mismatch_cnt <= 10) $display("%0t: mismatch: %s", $time, msg);
    endfunction

    function void write_reg(reg_e idx, logic [ApbDataW-1:0] value);
      case (idx)
        RegDebounce:  debounce_ms = value[DurW-1:0];
        RegLongPress: long_press_ms = value[DurW-1:0];
        RegCombo:     combo_threshold = value[CountW-1:0];
        default: ;
      endcase
    endfunction

    function logic [ApbDataW-1:0] reg_value(reg_e idx);
      case (idx)
        RegDebounce:  return ApbDataW'(debounce_ms);
        RegLongPress: return ApbDataW'(long_press_ms);
        RegCombo:     return ApbDataW'(combo_threshold);
        default:      return '0;
      endcase
    endfunction

    function void take_sample(logic level, logic [TimeW-1:0] now);
      ev_e              codes[$];
      logic [TimeW-1:0] elapsed;
      if (level == held_level) begin
        elapsed = now - change_time;
        if (change_pending && elapsed >= TimeW'(debounce_ms)) begin
          change_pending = 1'b0;
          if (held_level == 1'b0) begin
            is_down = 1'b1;
            codes.push_back(EvDown);
            if (press_count != CountMax) press_count++;
            if (press_count >= combo_threshold) codes.push_back(EvCombo);
          end else begin
            is_down = 1'b0;
            codes.push_back(EvUp);
          end
        end
      end else begin
        change_pending = 1'b1;
        held_level     = level;
        change_time    = now;
      end
      elapsed = now - change_time;
      if (is_down && elapsed >= TimeW'(long_press_ms)) begin
        is_down = 1'b0;
        codes.push_back(EvLong);
      end
      foreach (codes[i]) begin
        due_events.push_back(ev_word_t'{code: codes[i], last: logic'(i == codes.size() - 1)});
      end
    endfunction

    function void check_event(logic [1:0] code, logic last);
      ev_word_t want;
      if (due_events.size() == 0) begin
        report($sformatf("unexpected event word: code %0d last %0b", code, last));
        return;
      end
      want = due_events.pop_front();
      if (code !== want.code) begin
        report($sformatf("event code: expected %s, got %0d", want.code.name(), code));
      end
      if (last !== want.last) begin
        report($sformatf("last flag on %s: expected %0b, got %0b", want.code.name(), want.last,
                         last));
      end
    endfunction
  endclass

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [ApbAddrW-1:0] paddr;
  logic [ApbDataW-1:0] pwdata;
  logic [ApbDataW-1:0] prdata;
  logic                pready;

  bdet_sample_if sample_if ();
  bdet_event_if  ev_if ();

  press_event_tracker tracker = new();

  // idle percentages of the sample sender and the event receiver
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;

  // running millisecond clock and the level the random presses aim for
  logic [TimeW-1:0] clock_ms;
  logic             intent;

  button_press_event_detector u_top (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sample_i (sample_if),
    .event_o  (ev_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // event receiver stalls at random, the rate set by the current idling mode
  always @(posedge clk_i) begin
    ev_if.ready <= ($urandom_range(0, 99) >= snk_idle_pct);
  end

  // every accepted event word goes to the tracker, pre-edge values sampled
  always @(posedge clk_i) begin
    if (rst_ni && ev_if.valid && ev_if.ready) begin
      tracker.check_event(ev_if.event_res, ev_if.last);
    end
  end

  // hands one sample word over, idling first at the sender's rate
  task automatic send_sample(input logic level, input logic [TimeW-1:0] now);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      sample_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    sample_if.valid  <= 1'b1;
    sample_if.level  <= level;
    sample_if.now_ms <= now;
    @(posedge clk_i);
    while (!sample_if.ready) @(posedge clk_i);
    tracker.take_sample(level, now);
  endtask

  // stop sending, let every due event word drain, then allow for a sample
  // that caused nothing still being on its way through
  task automatic settle();
    sample_if.valid <= 1'b0;
    while (tracker.due_events.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // apb read of one register, compared with the tracker's copy; leaves the
  // bus idle before returning so the next transfer starts on a fresh step
  task automatic reg_check(input reg_e idx);
    logic [ApbDataW-1:0] got;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ApbAddrW'(int'(idx) * 4);
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    if (got !== tracker.reg_value(idx)) begin
      tracker.report($sformatf("register %s read back: expected %0d, got %0d", idx.name(),
                               tracker.reg_value(idx), got));
    end
  endtask

  // apb write followed by a read-back; the read's setup phase takes over the bus
  task automatic reg_write(input reg_e idx, input logic [ApbDataW-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(int'(idx) * 4);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    tracker.write_reg(idx, value);
    reg_check(idx);
  endtask

  // zero or the top of the range now and then, else a typical value
  function automatic logic [ApbDataW-1:0] pick_setting(int unsigned top, int unsigned typical);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick == 0) return '0;
    if (pick == 1) return ApbDataW'(top);
    return ApbDataW'($urandom_range(0, typical));
  endfunction

  // one random setting, then mostly press and release sequences with bounce
  // and random gaps, plus some noise words with arbitrary time stamps
  task automatic run_random_phase(input int unsigned count);
    int unsigned      pick;
    int unsigned      deb;
    int unsigned      lp;
    logic             lvl;
    logic [TimeW-1:0] stamp;
    settle();
    reg_write(RegDebounce, pick_setting(65535, 40));
    reg_write(RegLongPress, pick_setting(65535, 400));
    reg_write(RegCombo, pick_setting(255, 12));
    deb = 32'(tracker.debounce_ms);
    lp  = 32'(tracker.long_press_ms);
    for (int unsigned k = 0; k < count; k++) begin
      // now and then the sender holds off until every event word is back
      if ($urandom_range(0, 24) == 0) settle();
      pick = $urandom_range(0, 99);
      if (pick < 8) begin
        lvl      = 1'($urandom_range(0, 1));
        stamp    = $urandom();
        clock_ms = stamp;
      end else begin
        if (pick < 30) intent = ~intent;
        lvl = ($urandom_range(0, 9) == 0) ? ~intent : intent;
        case ($urandom_range(0, 3))
          0:       clock_ms += $urandom_range(0, deb / 2);
          1:       clock_ms += deb + $urandom_range(0, 10);
          2:       clock_ms += $urandom_range(0, lp + lp / 2 + 10);
          default: clock_ms += $urandom_range(1, 5);
        endcase
        stamp = clock_ms;
      end
      send_sample(lvl, stamp);
    end
  endtask

  initial begin
    rst_ni           <= 1'b0;
    sample_if.valid  <= 1'b0;
    sample_if.level  <= 1'b1;
    sample_if.now_ms <= '0;
    psel             <= 1'b0;
    penable          <= 1'b0;
    pwrite           <= 1'b0;
    paddr            <= '0;
    pwdata           <= '0;
    src_idle_pct = 35;
    snk_idle_pct = 78;
    clock_ms     = '0;
    intent       = 1'b0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers should read back their defaults
    for (int i = 0; i < int'(RegNone); i++) reg_check(reg_e'(i));

    // default setting: startup high level, bounce, long press, combo on the
    // second press, time going back and time wrapping past the top
    send_sample(1'b1, 32'd0);
    send_sample(1'b1, 32'd10);
    send_sample(1'b1, 32'd20);
    send_sample(1'b0, 32'd100);
    send_sample(1'b1, 32'd105);
    send_sample(1'b0, 32'd110);
    send_sample(1'b0, 32'd130);
    send_sample(1'b0, 32'd1129);
    send_sample(1'b1, 32'd1200);
    send_sample(1'b1, 32'd1220);
    send_sample(1'b0, 32'd1300);
    send_sample(1'b0, 32'd1320);
    send_sample(1'b1, 32'd1400);
    send_sample(1'b1, 32'd5);
    send_sample(1'b0, 32'hFFFF_FFF8);
    send_sample(1'b0, 32'h0000_0010);
    send_sample(1'b0, 32'hFFFF_FFFF);

    // zero debounce, zero long press, zero threshold: down, combo and long
    // all from one word
    settle();
    reg_write(RegDebounce, 32'd0);
    reg_write(RegLongPress, 32'd0);
    reg_write(RegCombo, 32'd0);
    send_sample(1'b1, 32'd50);
    send_sample(1'b1, 32'd50);
    send_sample(1'b0, 32'd60);
    send_sample(1'b0, 32'd60);

    // top of every range: debounce edge, long press in the same word as down
    settle();
    reg_write(RegDebounce, 32'd65535);
    reg_write(RegLongPress, 32'd65535);
    reg_write(RegCombo, 32'd255);
    send_sample(1'b1, 32'd0);
    send_sample(1'b1, 32'd65534);
    send_sample(1'b1, 32'd65535);
    send_sample(1'b0, 32'd70000);
    send_sample(1'b0, 32'd135535);
    send_sample(1'b0, 32'd201070);
    clock_ms = 32'd201100;

    // random part over the three idling modes
    repeat (2) run_random_phase(25);
    src_idle_pct = 78;
    snk_idle_pct = 35;
    repeat (2) run_random_phase(25);
    src_idle_pct = 0;
    snk_idle_pct = 0;
    repeat (2) run_random_phase(25);

    // short press storm at zero debounce, combo held off by the top threshold
    settle();
    reg_write(RegDebounce, 32'd0);
    reg_write(RegLongPress, 32'd65535);
    reg_write(RegCombo, 32'd255);
    repeat (6) begin
      send_sample(1'b0, clock_ms);
      send_sample(1'b0, clock_ms + 1);
      send_sample(1'b1, clock_ms + 2);
      send_sample(1'b1, clock_ms + 3);
      clock_ms += 4;
    end

    settle();
    if (tracker.mismatch_cnt == 0 && tracker.due_events.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hard stop well beyond the slowest correct run
  initial begin
    #20_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
